FILE: rtl/bitmap_page_allocator_core_macros.svh
// Assertion macros for the bitmap page allocator.
// Used by the top level; every macro expects clk and rst in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define BPA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define BPA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/bpa_pkg.sv
// Shared constants, codes and types of the bitmap page allocator.
// No dependencies; every other file but the macro header imports this package.
package bpa_pkg;

  localparam int NUM_PAGES     = 65536;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = NUM_PAGES / MAP_WORD_BITS;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int WCNT_W        = WORD_AW + 1;
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);

  localparam int PAGE_W     = 17;
  localparam int KB_W       = 22;
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PN_W       = ADDR_W - PAGE_SHIFT;
  localparam int KB_FIRST_MB = 1024;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = KB_W;

  localparam logic [CFG_AW-1:0] CFG_UPPER_KB   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FIRST_PAGE = 2'd1;

  localparam logic [KB_W-1:0]   UPPER_KB_RST   = 22'd261120;
  localparam logic [PAGE_W-1:0] FIRST_PAGE_RST = 17'd4096;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } hit_t;

endpackage

FILE: rtl/bpa_req_if.sv
// Request channel of the bitmap page allocator: opcode and page address.
// Depends on bpa_pkg.
interface bpa_req_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  op_t               op;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, op, page_address, input ready);
  modport sink   (input valid, op, page_address, output ready);
endinterface

FILE: rtl/bpa_rsp_if.sv
// Response channel of the bitmap page allocator: address, status, free count.
// Depends on bpa_pkg.
interface bpa_rsp_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] granted_address;
  status_t           status;
  logic [PAGE_W-1:0] free_pages;

  modport source (output valid, granted_address, status, free_pages, input ready);
  modport sink   (input valid, granted_address, status, free_pages, output ready);
endinterface

FILE: rtl/bpa_cfg_if.sv
// Register write channel of the bitmap page allocator.
// Depends on bpa_pkg.
interface bpa_cfg_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/bpa_word_eval.sv
// Per-word evaluation: which bits of a map word lie in the usable page range,
// and the lowest free one among them. Depends on bpa_pkg.
module bpa_word_eval (
  input  logic [bpa_pkg::WORD_AW-1:0]       word,
  input  logic [bpa_pkg::PAGE_W-1:0]        first_page,
  input  logic [bpa_pkg::PAGE_W-1:0]        limit,
  input  logic [bpa_pkg::MAP_WORD_BITS-1:0] data,
  output logic [bpa_pkg::MAP_WORD_BITS-1:0] range_mask,
  output bpa_pkg::hit_t                     hit
);
  import bpa_pkg::*;

  logic [MAP_WORD_BITS-1:0] avail;

  for (genvar g = 0; g < MAP_WORD_BITS; g++) begin : g_bit
    logic [PAGE_W-1:0] pg;
    assign pg = PAGE_W'({word, BIT_W'(g)});
    assign range_mask[g] = (pg >= first_page) && (pg < limit);
  end

  assign avail = ~data & range_mask;

  // lowest free bit wins
  always_comb begin
    hit.found = |avail;
    hit.idx   = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit.idx = BIT_W'(b);
      end
    end
  end

endmodule

FILE: rtl/bitmap_page_allocator_core.sv
// Bitmap page-frame allocator over 4 KB pages, top level.
// Depends on bpa_pkg, the channel interfaces, bpa_word_eval and the macro header.
//
// Usage: items arrive on req (op, page_address) and each yields exactly one
// transfer on rsp (granted_address, status, free_pages). Registers are written
// on cfg (index 0 upper memory in KB, index 1 first usable page) only while
// idle, a rule the user must keep, as the block does not enforce it; cfg is
// always ready and other indexes are dropped. One item is worked on at a time;
// the used map is a 2048 x 32 bit synchronous RAM for scans, in-range frees, init.
//   free  : read word, modify, write.
//   alloc : scan map words in turn; the scan starts at a hint word below
//           which no page is free.
//   init  : one RAM write per map word.
// Reset: a clearing pass writes every word as used; req.ready
// stays low during the pass, cfg writes are still taken.
// Stall: a result waits in the rsp register; one further item is accepted
// and worked on, and its result waits until rsp is taken.
`include "bitmap_page_allocator_core_macros.svh"

module bitmap_page_allocator_core (
  input logic      clk,
  input logic      rst,
  bpa_req_if.sink  req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink  cfg
);
  import bpa_pkg::*;

  state_t state, state_next;

  logic [KB_W-1:0]   upper_kb;
  logic [PAGE_W-1:0] first_page;
  logic [PAGE_W-1:0] page_limit, page_limit_next;
  logic [PAGE_W-1:0] free_count, free_count_next;
  logic [WCNT_W-1:0] hint, hint_next;
  logic [WCNT_W-1:0] scan_word, scan_word_next;
  logic [WORD_AW-1:0] chk_word, chk_word_next;
  logic              chk_valid, chk_valid_next;
  logic [WORD_AW-1:0] sweep_word, sweep_word_next;
  logic              sweep_init, sweep_init_next;
  logic [WORD_AW-1:0] free_word, free_word_next;
  logic [BIT_W-1:0]  free_bit, free_bit_next;

  logic [ADDR_W-1:0] res_granted, res_granted_next;
  status_t           res_status, res_status_next;
  logic [PAGE_W-1:0] res_free, res_free_next;
  logic              out_load;

  // map RAM
  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] rd_data, wr_data;
  logic [WORD_AW-1:0]       rd_addr, wr_addr;
  logic                     rd_en, wr_en;

  // derived values
  logic [KB_W:0]       kb_sum, lim_q;
  logic [PAGE_W-1:0]   new_limit, init_count, count_dec;
  logic [WCNT_W-1:0]   first_word, end_word, start_word;
  logic                hint_ok;
  logic [PN_W-1:0]     req_page;
  logic                free_in_range;
  logic [PAGE_W-1:0]   grant_page;
  logic                scan_chk;
  logic                grant_ok;

  logic [WORD_AW-1:0]       eval_word;
  logic [MAP_WORD_BITS-1:0] range_mask;
  hit_t                     hit;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_kb   <= UPPER_KB_RST;
      first_page <= FIRST_PAGE_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_UPPER_KB:   upper_kb   <= cfg.data[KB_W-1:0];
        CFG_FIRST_PAGE: first_page <= cfg.data[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign kb_sum    = (KB_W + 1)'(upper_kb) + (KB_W + 1)'(KB_FIRST_MB);
  assign lim_q     = kb_sum >> 2;
  assign new_limit = (lim_q > (KB_W + 1)'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES) : PAGE_W'(lim_q);
  assign init_count = (page_limit > first_page) ? page_limit - first_page : '0;
  assign count_dec  = (free_count == '0) ? '0 : free_count - PAGE_W'(1);

  assign first_word = WCNT_W'(first_page >> BIT_W);
  assign end_word   = WCNT_W'(page_limit >> BIT_W) + WCNT_W'(|page_limit[BIT_W-1:0]);
  assign start_word = (hint > first_word) ? hint : first_word;
  // the hint may advance only when no scanned bit was hidden below the first page
  assign hint_ok    = (hint > first_word) ||
                      ((hint == first_word) && (first_page[BIT_W-1:0] == '0));

  assign req_page      = req.page_address[ADDR_W-1:PAGE_SHIFT];
  assign free_in_range = (req_page >= PN_W'(first_page)) && (req_page < PN_W'(page_limit));

  assign eval_word  = (state == S_SWEEP) ? sweep_word : chk_word;
  assign grant_page = PAGE_W'({chk_word, hit.idx});
  assign scan_chk   = (state == S_SCAN) && chk_valid;
  assign grant_ok   = (grant_page >= first_page) && (grant_page < page_limit);

  bpa_word_eval u_eval (
    .word       (eval_word),
    .first_page (first_page),
    .limit      (page_limit),
    .data       (rd_data),
    .range_mask (range_mask),
    .hit        (hit)
  );

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_word <= '0;
      sweep_init <= 1'b0;
      page_limit <= '0;
      free_count <= '0;
      hint       <= '0;
      chk_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_word <= sweep_word_next;
      sweep_init <= sweep_init_next;
      page_limit <= page_limit_next;
      free_count <= free_count_next;
      hint       <= hint_next;
      chk_valid  <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_word   <= scan_word_next;
    chk_word    <= chk_word_next;
    free_word   <= free_word_next;
    free_bit    <= free_bit_next;
    res_granted <= res_granted_next;
    res_status  <= res_status_next;
    res_free    <= res_free_next;
  end

  always_comb begin
    state_next       = state;
    sweep_word_next  = sweep_word;
    sweep_init_next  = sweep_init;
    page_limit_next  = page_limit;
    free_count_next  = free_count;
    hint_next        = hint;
    scan_word_next   = scan_word;
    chk_word_next    = chk_word;
    chk_valid_next   = chk_valid;
    free_word_next   = free_word;
    free_bit_next    = free_bit;
    res_granted_next = res_granted;
    res_status_next  = res_status;
    res_free_next    = res_free;
    rd_en            = 1'b0;
    rd_addr          = scan_word[WORD_AW-1:0];
    wr_en            = 1'b0;
    wr_addr          = sweep_word;
    wr_data          = ~range_mask;
    out_load         = 1'b0;

    unique case (state)
      S_SWEEP: begin
        // rewrite one word per cycle; page_limit of zero clears to all used
        wr_en           = 1'b1;
        sweep_word_next = sweep_word + WORD_AW'(1);
        if (sweep_word == WORD_AW'(MAP_WORDS - 1)) begin
          sweep_init_next = 1'b0;
          if (sweep_init) begin
            free_count_next  = init_count;
            res_granted_next = '0;
            res_status_next  = ST_OK;
            res_free_next    = init_count;
            state_next       = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        rd_addr = req_page[BIT_W +: WORD_AW];
        if (req.valid) begin
          res_granted_next = '0;
          res_status_next  = ST_OK;
          res_free_next    = free_count;
          unique case (req.op)
            OP_INIT: begin
              page_limit_next = new_limit;
              free_count_next = '0;
              hint_next       = first_word;
              sweep_word_next = '0;
              sweep_init_next = 1'b1;
              state_next      = S_SWEEP;
            end
            OP_ALLOC: begin
              if (start_word >= end_word) begin
                res_status_next = ST_OOM;
                state_next      = S_DONE;
              end else begin
                scan_word_next = start_word;
                chk_valid_next = 1'b0;
                state_next     = S_SCAN;
              end
            end
            OP_FREE: begin
              if (free_in_range) begin
                rd_en          = 1'b1;
                free_word_next = req_page[BIT_W +: WORD_AW];
                free_bit_next  = req_page[BIT_W-1:0];
                state_next     = S_FREE_CHK;
              end else begin
                res_status_next = ST_IGNORED;
                state_next      = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next word while checking the one read last cycle
        rd_en   = (scan_word < end_word);
        rd_addr = scan_word[WORD_AW-1:0];
        if (rd_en) begin
          scan_word_next = scan_word + WCNT_W'(1);
        end
        chk_valid_next = rd_en;
        chk_word_next  = scan_word[WORD_AW-1:0];
        if (chk_valid) begin
          if (hit.found) begin
            wr_en            = 1'b1;
            wr_addr          = chk_word;
            wr_data          = rd_data | (MAP_WORD_BITS'(1) << hit.idx);
            free_count_next  = count_dec;
            res_free_next    = count_dec;
            res_granted_next = ADDR_W'({chk_word, hit.idx, {PAGE_SHIFT{1'b0}}});
            if (hint_ok) begin
              hint_next = WCNT_W'(chk_word);
            end
            chk_valid_next = 1'b0;
            state_next     = S_DONE;
          end else if (WCNT_W'(chk_word) == end_word - WCNT_W'(1)) begin
            res_status_next = ST_OOM;
            chk_valid_next  = 1'b0;
            state_next      = S_DONE;
          end
        end
      end

      S_FREE_CHK: begin
        if (rd_data[free_bit]) begin
          wr_en           = 1'b1;
          wr_addr         = free_word;
          wr_data         = rd_data & ~(MAP_WORD_BITS'(1) << free_bit);
          free_count_next = free_count + PAGE_W'(1);
          res_free_next   = free_count + PAGE_W'(1);
          if (WCNT_W'(free_word) < hint) begin
            hint_next = WCNT_W'(free_word);
          end
        end else begin
          res_status_next = ST_IGNORED;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.granted_address <= res_granted;
      rsp.status          <= res_status;
      rsp.free_pages      <= res_free;
    end
  end

  `BPA_ASSERT_IMPLY(a_grant_in_range, scan_chk && hit.found, grant_ok, "grant out of range")
  `BPA_ASSERT_IMPLY(a_scan_window, scan_chk, WCNT_W'(chk_word) < end_word, "scan past page limit")
  `BPA_ASSERT_ALWAYS(a_count_bound, free_count <= page_limit, "free count exceeds page limit")
  `BPA_ASSERT_IMPLY(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr, "map read/write clash")

endmodule
